FILE: rtl/core/chained_hash_map_engine_macros.svh
// Assertion macros for the chained hash map engine.
// Each macro expects clk_i and rst_ni in the enclosing module's scope.
`ifndef CHAINED_HASH_MAP_ENGINE_MACROS_SVH
`define CHAINED_HASH_MAP_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("chm assertion failed");
`define CHM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chm assertion failed");
`else
`define CHM_ASSERT(lbl, prop)
`define CHM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/chm_pkg.sv
// Shared types and constants of the chained hash map engine.
// No dependencies.
`default_nettype none
package chm_pkg;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int TOT_W   = 13;
  localparam int CFG_W   = 9;
  localparam int DIV_STEPS = 16;   // two remainder bits per cycle over 32 key bits
  localparam int FILL_NUM = 5;     // 0.8 fill limit as (count+1)*5 < buckets*factor*4
  localparam int FILL_DEN = 4;
  localparam logic [CFG_W-1:0] BUCKETS_RESET = 9'd256;
  localparam logic REG_BUCKET_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4
  } chm_status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_HEAD_RD, S_HEAD, S_WALK, S_RES, S_LINK, S_OUT
  } chm_state_e;

  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] rem;
  } chm_div_t;
endpackage
`default_nettype wire

FILE: rtl/core/chm_req_if.sv
// Request channel: put or get beat with key and value.
// No dependencies.
`default_nettype none
interface chm_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] key;
  logic [31:0] value;
  modport source (output valid, req_type, key, value, input ready);
  modport sink   (input valid, req_type, key, value, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/chm_rsp_if.sv
// Response channel: status, read value and entry total.
// No dependencies.
`default_nettype none
interface chm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] read_value;
  logic [12:0] entry_total;
  modport source (output valid, status, read_value, entry_total, input ready);
  modport sink   (input valid, status, read_value, entry_total, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/chm_mod.sv
// Key modulo bucket count, radix-4 restoring remainder: 16 steps, done flagged together
// with the registered result of the last step. Depends on chm_pkg.
`default_nettype none
module chm_mod (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [31:0]           key_i,
  input  logic [8:0]            nb_i,
  output chm_pkg::chm_div_t     div_o
);
  import chm_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [3:0]       cnt_q;
  logic [KEY_W-1:0] shift_q;
  logic [CFG_W-1:0] rem_q;
  logic [CFG_W-1:0] rem_d;

  always_comb begin
    logic [CFG_W:0] t;
    rem_d = rem_q;
    for (int i = 0; i < 2; i++) begin
      t = {rem_d, shift_q[KEY_W-1-i]};
      if (t >= {1'b0, nb_i}) begin
        rem_d = CFG_W'(t - {1'b0, nb_i});
      end else begin
        rem_d = t[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == 4'(DIV_STEPS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= key_i;
      rem_q   <= '0;
    end else if (busy_q) begin
      shift_q <= {shift_q[KEY_W-3:0], 2'b00};
      rem_q   <= rem_d;
    end
  end

  assign div_o = '{done: done_q, rem: rem_q};
endmodule
`default_nettype wire

FILE: rtl/core/chained_hash_map_engine.sv
// Channel | dir | beat contents
// req     | in  | req_type, key, value
// rsp     | out | status, read_value, entry_total
// apb     | in  | bucket_count at byte address 0
// One request at a time: key modulo (16 radix-4 steps and a done flag), then a head
// read (S_HEAD_RD, S_HEAD), then one chain node visited at a time (single read port of
// the node memory), write-back in S_RES, with S_LINK added for an insert behind an
// existing head, loading of the response register in S_OUT and a return to S_IDLE to
// take the next beat. After reset a clearing pass zeroes the bucket heads with req
// not ready. A pending response does not block the next request until the next
// response is ready to load.
// Depends on chm_pkg, chm_req_if, chm_rsp_if, chm_mod and the macros header.
`default_nettype none
`include "chained_hash_map_engine_macros.svh"
module chained_hash_map_engine #(
  parameter int MAX_BUCKETS   = 256,
  parameter int BUCKET_FACTOR = 16,
  parameter int NODE_DEPTH    = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chm_req_if.sink     req,
  chm_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import chm_pkg::*;

  localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NAW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int LW  = $clog2(NODE_DEPTH + 1);
  localparam int NW  = KEY_W + VAL_W + LW;
  localparam int LIM_MUL = BUCKET_FACTOR * FILL_DEN;

  chm_state_e state_q, state_d;
  logic [BW-1:0]    clr_q;
  logic [CFG_W-1:0] bcnt_q;
  logic [CFG_W-1:0] nb;
  logic             type_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [BW-1:0]    bucket_q;
  logic [LW-1:0]    count_q;
  chm_div_t         div;

  logic [LW-1:0] head_mem [MAX_BUCKETS];
  logic [LW-1:0] head_rd_q;
  logic          head_re, head_we;
  logic [BW-1:0] head_waddr;
  logic [LW-1:0] head_wdata;

  logic [NW-1:0]  node_mem [NODE_DEPTH];
  logic [NW-1:0]  node_rd_q;
  logic           node_re, node_we;
  logic [NAW-1:0] node_raddr, node_waddr;
  logic [NW-1:0]  node_wdata;

  logic           first_q, found_q, hempty_q;
  logic [NW-1:0]  hword_q;
  logic [NAW-1:0] hidx_q, cur_q;
  chm_status_e    stat_q;
  logic [VAL_W-1:0] rv_q;

  logic             ov_q;
  chm_status_e      ostat_q;
  logic [VAL_W-1:0] orv_q;
  logic [TOT_W-1:0] otot_q;

  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic [LW-1:0]    rd_next;
  logic             match, full, ins, out_load;
  logic [31:0]      need, lim;

  assign rd_key  = node_rd_q[NW-1 -: KEY_W];
  assign rd_val  = node_rd_q[LW +: VAL_W];
  assign rd_next = node_rd_q[LW-1:0];
  assign match   = (rd_key == key_q);

  assign nb = (bcnt_q == '0) ? CFG_W'(1) :
              (32'(bcnt_q) > MAX_BUCKETS) ? CFG_W'(MAX_BUCKETS) : bcnt_q;

  assign need = (32'(count_q) + 32'd1) * 32'(FILL_NUM);
  assign lim  = 32'(nb) * 32'(LIM_MUL);
  assign full = (need >= lim) || (32'(count_q) >= NODE_DEPTH);
  assign ins  = !type_q && !found_q && !full;
  assign out_load = (state_q == S_OUT) && (!ov_q || rsp.ready);

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? 32'(bcnt_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= BUCKETS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BUCKET_COUNT) begin
      bcnt_q <= pwdata[CFG_W-1:0];
    end
  end

  chm_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(req.valid && req.ready),
    .key_i  (req.key),
    .nb_i   (nb),
    .div_o  (div)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (clr_q == BW'(MAX_BUCKETS - 1)) state_d = S_IDLE;
      S_IDLE:    if (req.valid) state_d = S_DIV;
      S_DIV:     if (div.done) state_d = S_HEAD_RD;
      S_HEAD_RD: state_d = S_HEAD;
      S_HEAD:    state_d = (head_rd_q == '0) ? S_RES : S_WALK;
      S_WALK:    if (match || rd_next == '0) state_d = S_RES;
      S_RES:     state_d = (ins && !hempty_q) ? S_LINK : S_OUT;
      S_LINK:    state_d = S_OUT;
      S_OUT:     if (!ov_q || rsp.ready) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    head_re    = (state_q == S_HEAD_RD);
    head_we    = 1'b0;
    head_waddr = bucket_q;
    head_wdata = '0;
    node_re    = 1'b0;
    node_raddr = NAW'(head_rd_q - LW'(1));
    node_we    = 1'b0;
    node_waddr = cur_q;
    node_wdata = {key_q, val_q, rd_next};
    case (state_q)
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
      end
      S_HEAD: begin
        node_re = (head_rd_q != '0);
      end
      S_WALK: begin
        node_re    = !match && (rd_next != '0);
        node_raddr = NAW'(rd_next - LW'(1));
      end
      S_RES: begin
        if (!type_q && found_q) begin
          node_we = 1'b1;
        end else if (ins) begin
          node_we    = 1'b1;
          node_waddr = NAW'(count_q);
          node_wdata = {key_q, val_q, hempty_q ? LW'(0) : hword_q[LW-1:0]};
          head_we    = hempty_q;
          head_wdata = count_q + LW'(1);
        end
      end
      S_LINK: begin
        // splice the new node right after the bucket head
        node_we    = 1'b1;
        node_waddr = hidx_q;
        node_wdata = {hword_q[NW-1:LW], count_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    if (head_re) head_rd_q <= head_mem[bucket_q];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    if (node_re) node_rd_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      count_q <= '0;
      ov_q    <= 1'b0;
      found_q <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + BW'(1);
      if (req.valid && req.ready) found_q <= 1'b0;
      if (state_q == S_HEAD) first_q <= 1'b1;
      if (state_q == S_WALK) begin
        first_q <= 1'b0;
        if (match) found_q <= 1'b1;
      end
      if (state_q == S_RES && ins) count_q <= count_q + LW'(1);
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (rsp.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      type_q <= req.req_type;
      key_q  <= req.key;
      val_q  <= req.value;
    end
    if (state_q == S_DIV && div.done) bucket_q <= BW'(div.rem);
    if (state_q == S_HEAD) begin
      hempty_q <= (head_rd_q == '0);
      cur_q    <= NAW'(head_rd_q - LW'(1));
    end
    if (state_q == S_WALK) begin
      if (first_q) begin
        hword_q <= node_rd_q;
        hidx_q  <= cur_q;
      end
      if (node_re) cur_q <= node_raddr;
    end
    if (state_q == S_RES) begin
      rv_q <= (type_q && found_q) ? rd_val : '0;
      if (type_q) begin
        stat_q <= found_q ? ST_HIT : ST_MISS;
      end else if (found_q) begin
        stat_q <= ST_UPDATED;
      end else begin
        stat_q <= full ? ST_FULL : ST_INSERTED;
      end
    end
    if (out_load) begin
      ostat_q <= stat_q;
      orv_q   <= rv_q;
      otot_q  <= TOT_W'(count_q);
    end
  end

  assign req.ready        = (state_q == S_IDLE);
  assign rsp.valid        = ov_q;
  assign rsp.status       = ostat_q;
  assign rsp.read_value   = orv_q;
  assign rsp.entry_total  = otot_q;

  `CHM_ASSERT_NEXT(a_count_mono, 1'b1, count_q >= $past(count_q))
  `CHM_ASSERT(a_count_bound, 32'(count_q) <= NODE_DEPTH)
  `CHM_ASSERT_NEXT(a_beat_starts_div, req.valid && req.ready, state_q == S_DIV)
  `CHM_ASSERT_NEXT(a_ins_counts, state_q == S_RES && ins, count_q == $past(count_q) + LW'(1))
endmodule
`default_nettype wire
